### hw/rtl/sliding_window_median_filter_macros.svh
// Assertion macros used by the median filter top module.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH
`ifndef SYNTH
`define SWMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define SWMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWMF_ASSERT(label, prop, msg)
`define SWMF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/swmf_pkg.sv
package swmf_pkg;

  localparam int KERNEL_WIDTH  = 3;
  localparam int KERNEL_HEIGHT = 3;
  localparam int MAX_WIDTH     = 2048;

  localparam int WIN_N      = KERNEL_WIDTH * KERNEL_HEIGHT;
  localparam int STORE_ROWS = KERNEL_HEIGHT - 1;
  localparam int RANK_MID   = WIN_N / 2;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int EFF_W     = CFG_W + 1;
  localparam int OUT_COL_W = 11;

  localparam int OUT_FIELDS_W = PIX_W + ROW_W + OUT_COL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [STORE_ROWS-1:0] line_word_t;
  typedef pix_t [WIN_N-1:0] win_flat_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } lb_ctrl_t;

endpackage

### hw/rtl/swmf_line_buf.sv
module swmf_line_buf import swmf_pkg::*; (
  input  logic       clk,
  input  lb_ctrl_t   ctrl,
  input  pix_t       wr_px,
  output line_word_t rd_word
);

  line_word_t line_mem_r [MAX_WIDTH];
  line_word_t rd_q_r;
  line_word_t byp_r;
  logic       byp_sel_r;
  line_word_t wr_word;

  // oldest row drops out, new pixel enters at the top
  always_comb begin
    for (int i = 0; i < STORE_ROWS - 1; i++) begin
      wr_word[i] = rd_word[i+1];
    end
    wr_word[STORE_ROWS-1] = wr_px;
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      line_mem_r[ctrl.wr_addr] <= wr_word;
    end
  end

  // same-cycle write to the read column (one-pixel rows) is forwarded
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q_r    <= line_mem_r[ctrl.rd_addr];
      byp_r     <= wr_word;
      byp_sel_r <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
    end
  end

  assign rd_word = byp_sel_r ? byp_r : rd_q_r;

endmodule

### hw/rtl/swmf_median.sv
module swmf_median import swmf_pkg::*; (
  input  win_flat_t win,
  output pix_t      median
);

  logic [WIN_N-1:0] below [WIN_N];
  logic [WIN_N-1:0] is_mid;

  // rank of each tap: count of taps that sort ahead of it, ties by position
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        below[i][j] = (j < i) ? (win[j] <= win[i]) : (win[j] < win[i]);
      end
      is_mid[i] = ($countones(below[i]) == RANK_MID);
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WIN_N; i++) begin
      median = median | (is_mid[i] ? win[i] : '0);
    end
  end

endmodule

### hw/rtl/sliding_window_median_filter.sv
// Channel  Role        Beat
// in_*     stream in   tdata[7:0] pixel, raster order
// out_*    stream out  tdata median, center row, center col; tlast on last result of frame
// cfg_*    APB slave   0x0 frame_width, 0x4 frame_height (12 bits each)
//
// One pixel per clock sustained while the output register drains; a result passes
// the line store read, the window shift and the median into the output register.
// Reset clears counters, window and valid flags and loads the frame size defaults; line store is not cleared.
// A config write restarts the frame at row 0, column 0.
// in_tready drops only while the output register is full and out_tready is low.
`include "sliding_window_median_filter_macros.svh"
module sliding_window_median_filter import swmf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,   // [7:0] pixel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] median, [19:8] out_row, [30:20] out_col, pad
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int ROW_OFS = KERNEL_HEIGHT - 1 - KERNEL_HEIGHT / 2;
  localparam int COL_OFS = KERNEL_WIDTH - 1 - KERNEL_WIDTH / 2;

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  logic [COL_W-1:0] col_count_r;
  logic [ROW_W-1:0] row_count_r;
  logic [COL_W-1:0] col_count_nxt;
  logic [ROW_W-1:0] row_count_nxt;
  logic [EFF_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             col_last;
  logic             row_last;
  logic             win_hit;

  logic                 s1_valid_r;
  pix_t                 s1_px_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 s1_hit_r;
  logic [ROW_W-1:0]     s1_crow_r;
  logic [OUT_COL_W-1:0] s1_ccol_r;
  logic                 s1_last_r;

  logic                 s2_valid_r;
  logic                 s2_hit_r;
  logic [ROW_W-1:0]     s2_crow_r;
  logic [OUT_COL_W-1:0] s2_ccol_r;
  logic                 s2_last_r;

  logic                 out_valid_r;
  pix_t                 out_med_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic                 out_last_r;

  logic in_fire;
  logic out_free;
  logic s1_adv;
  logic s2_adv;

  pix_t [KERNEL_HEIGHT-1:0][KERNEL_WIDTH-1:0] window_r;
  pix_t [KERNEL_HEIGHT-1:0][KERNEL_WIDTH-1:0] window_nxt;
  pix_t [KERNEL_HEIGHT-1:0]                   column_v;
  win_flat_t  win_flat;
  pix_t       med;
  line_word_t rd_word;
  lb_ctrl_t   lb_ctrl;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_WIDTH;
      frame_height_r <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // frame position
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = EFF_W'(1);
    end else if (EFF_W'(frame_width_r) > EFF_W'(MAX_WIDTH)) begin
      w_eff = EFF_W'(MAX_WIDTH);
    end else begin
      w_eff = EFF_W'(frame_width_r);
    end
    h_eff    = (frame_height_r == '0) ? CFG_W'(1) : frame_height_r;
    col_last = (EFF_W'(col_count_r) == (w_eff - EFF_W'(1)));
    row_last = (row_count_r == ROW_W'(h_eff - CFG_W'(1)));
    win_hit  = (row_count_r >= ROW_W'(KERNEL_HEIGHT - 1)) &&
               (col_count_r >= COL_W'(KERNEL_WIDTH - 1));
    if (col_last) begin
      col_count_nxt = '0;
      row_count_nxt = row_last ? '0 : row_count_r + ROW_W'(1);
    end else begin
      col_count_nxt = col_count_r + COL_W'(1);
      row_count_nxt = row_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (cfg_wr) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_fire) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // pipeline flow
  assign out_free  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && (!s2_hit_r || out_free);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv && s2_hit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_tdata;
      s1_col_r  <= col_count_r;
      s1_hit_r  <= win_hit;
      s1_crow_r <= row_count_r - ROW_W'(ROW_OFS);
      s1_ccol_r <= OUT_COL_W'(col_count_r - COL_W'(COL_OFS));
      s1_last_r <= row_last && col_last;
    end
    if (s1_adv) begin
      s2_hit_r  <= s1_hit_r;
      s2_crow_r <= s1_crow_r;
      s2_ccol_r <= s1_ccol_r;
      s2_last_r <= s1_last_r;
    end
    if (s2_adv && s2_hit_r) begin
      out_med_r  <= med;
      out_row_r  <= s2_crow_r;
      out_col_r  <= s2_ccol_r;
      out_last_r <= s2_last_r;
    end
  end

  // line store
  always_comb begin
    lb_ctrl.rd_en   = in_fire;
    lb_ctrl.rd_addr = col_count_r;
    lb_ctrl.wr_en   = s1_adv;
    lb_ctrl.wr_addr = s1_col_r;
  end

  swmf_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .wr_px   (s1_px_r),
    .rd_word (rd_word)
  );

  // window
  always_comb begin
    for (int i = 0; i < STORE_ROWS; i++) begin
      column_v[i] = rd_word[i];
    end
    column_v[KERNEL_HEIGHT-1] = s1_px_r;
    for (int i = 0; i < KERNEL_HEIGHT; i++) begin
      for (int j = 0; j < KERNEL_WIDTH - 1; j++) begin
        window_nxt[i][j] = window_r[i][j+1];
      end
      window_nxt[i][KERNEL_WIDTH-1] = column_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_adv) begin
      window_r <= window_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL_HEIGHT; i++) begin
      for (int j = 0; j < KERNEL_WIDTH; j++) begin
        win_flat[i*KERNEL_WIDTH+j] = window_r[i][j];
      end
    end
  end

  swmf_median u_median (
    .win    (win_flat),
    .median (med)
  );

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_med_r};

  `SWMF_ASSERT(a_col_in_frame, EFF_W'(col_count_r) < w_eff, "column counter past frame width")
  `SWMF_ASSERT_NEXT(a_cfg_restart, cfg_wr, col_count_r == '0 && row_count_r == '0, "restart missed")
  `SWMF_ASSERT_NEXT(a_s1_load, in_fire, s1_valid_r, "accepted pixel lost before window stage")
  `SWMF_ASSERT(a_out_interior, out_valid_r |-> out_row_r >= ROW_W'(KERNEL_HEIGHT / 2), "border row out")

endmodule

### dv/tb_sliding_window_median_filter.sv
`timescale 1ns / 100ps

module tb_sliding_window_median_filter;
  import swmf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 64;
  localparam int HOLD_AFTER   = 8;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 720;
  localparam int CALM_ITEMS   = 150;

  typedef enum int unsigned {PX_UNIFORM, PX_CLUSTERED, PX_EXTREMES} px_style_t;

  typedef struct {
    pix_t                 median;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } median_beat_t;

  class median_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             lines[MAX_WIDTH][STORE_ROWS];
    pix_t             win[KERNEL_HEIGHT][KERNEL_WIDTH];
    int unsigned      row_at;
    int unsigned      col_at;
    median_beat_t     medians_due[$];
    int               errors;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      foreach (lines[c, k]) lines[c][k] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row_at = 0;
      col_at = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      if (r == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      row_at = 0;
      col_at = 0;
    endfunction

    function void check_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] got);
      logic [CFG_DATA_W-1:0] want;
      want = CFG_DATA_W'((r == REG_FRAME_WIDTH) ? width_reg : height_reg);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", r.name(), want, got);
        errors++;
      end
    endfunction

    function pix_t window_mid();
      pix_t vals[$];
      foreach (win[i, j]) vals.push_back(win[i][j]);
      vals.sort();
      return vals[RANK_MID];
    endfunction

    function void take_pixel(pix_t px);
      int unsigned  w;
      int unsigned  h;
      int unsigned  c;
      int unsigned  r;
      pix_t         column[KERNEL_HEIGHT];
      median_beat_t b;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      c = col_at;
      r = row_at;
      for (int i = 0; i < STORE_ROWS; i++) column[i] = lines[c][i];
      column[STORE_ROWS] = px;
      for (int i = 0; i + 1 < STORE_ROWS; i++) lines[c][i] = lines[c][i+1];
      lines[c][STORE_ROWS-1] = px;
      for (int i = 0; i < KERNEL_HEIGHT; i++) begin
        for (int j = 0; j + 1 < KERNEL_WIDTH; j++) win[i][j] = win[i][j+1];
        win[i][KERNEL_WIDTH-1] = column[i];
      end
      if (r >= KERNEL_HEIGHT - 1 && c >= KERNEL_WIDTH - 1) begin
        b.median = window_mid();
        b.row    = ROW_W'(r - (KERNEL_HEIGHT - 1) + KERNEL_HEIGHT / 2);
        b.col    = OUT_COL_W'(c - (KERNEL_WIDTH - 1) + KERNEL_WIDTH / 2);
        b.last   = (r == h - 1) && (c == w - 1);
        medians_due.push_back(b);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_at = c;
      row_at = r;
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      median_beat_t         want;
      pix_t                 got_med;
      logic [ROW_W-1:0]     got_row;
      logic [OUT_COL_W-1:0] got_col;
      got_med = tdata[PIX_W-1:0];
      got_row = tdata[PIX_W +: ROW_W];
      got_col = tdata[PIX_W+ROW_W +: OUT_COL_W];
      if (medians_due.size() == 0) begin
        $error("unexpected result beat: tdata %h tlast %b", tdata, tlast);
        errors++;
        return;
      end
      want = medians_due.pop_front();
      if (got_med !== want.median) begin
        $error("median: expected %0d, got %0d", want.median, got_med);
        errors++;
      end
      if (got_row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, got_row);
        errors++;
      end
      if (got_col !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, got_col);
        errors++;
      end
      if (tlast !== want.last) begin
        $error("last_of_frame: expected %0d, got %0d", want.last, tlast);
        errors++;
      end
    endfunction

    function void flush();
      foreach (medians_due[i]) begin
        $error("missing result: median %0d row %0d col %0d",
               medians_due[i].median, medians_due[i].row, medians_due[i].col);
        errors++;
      end
      medians_due.delete();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata    = '0;   // [7:0] pixel
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [7:0] median, [19:8] row, [30:20] col
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  bit                     calm = 1'b0;
  median_scoreboard       board;

  sliding_window_median_filter uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reg_write(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({r, 2'b00});
    cfg_pwdata  <= {(CFG_DATA_W-CFG_W)'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_reg(r, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(input cfg_reg_t r);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'({r, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.check_reg(r, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_read_check(REG_FRAME_WIDTH);
    reg_read_check(REG_FRAME_HEIGHT);
  endtask

  task automatic push_pixel(input pix_t px);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    board.take_pixel(px);
  endtask

  function automatic pix_t gen_pixel(input px_style_t style, input pix_t base);
    case (style)
      PX_CLUSTERED: return base ^ pix_t'($urandom_range(0, 3));
      PX_EXTREMES:  return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:      return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_pixels(input int unsigned count, input px_style_t style);
    pix_t base;
    base = pix_t'($urandom);
    repeat (count) push_pixel(gen_pixel(style, base));
  endtask

  // block goes idle: all medians back, then a SETTLE wait for beats with no result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.medians_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    int taken;
    bit long_done;
    gap       = 0;
    taken     = 0;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        board.match_result(out_tdata, out_tlast);
        taken++;
      end
      if (gap > 0) begin
        gap--;
      end else if (!long_done && taken >= HOLD_AFTER) begin
        gap       = LONG_HOLD;
        long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
      end
      out_tready <= (gap == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("sliding_window_median_filter regression: fail");
    $finish;
  end

  initial begin : stimulus
    pix_t        seed_px[25] = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hAA, 8'h55,
                                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                                 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h33, 8'hCC,
                                 8'h3C};
    int unsigned w_cur;
    int unsigned h_cur;
    int unsigned nw;
    int unsigned nh;
    int unsigned ew;
    int unsigned eh;
    int unsigned n;
    int unsigned sent;
    int unsigned mode;

    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_read_check(REG_FRAME_WIDTH);
    reg_read_check(REG_FRAME_HEIGHT);

    // smallest full frame
    set_frame(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) push_pixel(seed_px[i]);
    drain();
    // partial frame, cut short by the next write
    set_frame(12'd4, 12'd3);
    for (int i = 9; i < 20; i++) push_pixel(seed_px[i]);
    drain();
    // zero height / zero width
    set_frame(12'd3, 12'd0);
    for (int i = 20; i < 23; i++) push_pixel(seed_px[i]);
    drain();
    set_frame(12'd0, 12'd3);
    for (int i = 23; i < 25; i++) push_pixel(seed_px[i]);
    drain();

    // full frame long enough to ride out the long receiver hold
    set_frame(12'd16, 12'd16);
    send_pixels(16 * 16, PX_UNIFORM);
    drain();

    w_cur = 16;
    h_cur = 16;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent + CALM_ITEMS > RANDOM_ITEMS);
      case ($urandom_range(0, 9))
        0: begin
          nw = $urandom_range(0, 3);
          if (nw == 3) nw = $urandom_range(MAX_WIDTH + 1, 4095);
          nh = $urandom_range(3, 6);
        end
        1: begin
          nw = $urandom_range(3, 10);
          nh = $urandom_range(0, 2);
        end
        2: begin
          nw = $urandom_range(3, 4);
          nh = $urandom_range(10, 20);
        end
        3: begin
          nw = $urandom_range(20, 70);
          nh = $urandom_range(3, 4);
        end
        default: begin
          nw = $urandom_range(3, 9);
          nh = $urandom_range(3, 7);
        end
      endcase
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        nh = h_cur;
        reg_write(REG_FRAME_WIDTH, CFG_W'(nw));
      end else if (mode == 1) begin
        nw = w_cur;
        reg_write(REG_FRAME_HEIGHT, CFG_W'(nh));
      end else begin
        set_frame(CFG_W'(nw), CFG_W'(nh));
      end
      w_cur = nw;
      h_cur = nh;
      ew = (nw == 0) ? 1 : ((nw > MAX_WIDTH) ? MAX_WIDTH : nw);
      eh = (nh == 0) ? 1 : nh;
      if (ew * eh > 400)
        n = $urandom_range(5, 40);
      else if ($urandom_range(0, 3) == 0)
        n = $urandom_range(1, ew * eh);
      else
        n = ew * eh * $urandom_range(1, 2);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      send_pixels(n, px_style_t'($urandom_range(0, 2)));
      drain();
      sent += n;
    end

    board.flush();
    if (board.errors == 0)
      $display("sliding_window_median_filter regression: pass");
    else
      $display("sliding_window_median_filter regression: fail");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_line_buf.sv
hw/rtl/swmf_median.sv
hw/rtl/sliding_window_median_filter.sv
dv/tb_sliding_window_median_filter.sv
